>>> src/ptot_pkg.sv
// Shared types and constants of the price trigger order table.
// Used by the interfaces, the compare unit, the top level and the checker.
`default_nettype none

package ptot_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned EV_W    = 3;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned INS_W   = 16;
  localparam int unsigned PRICE_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER   = 2'd0,
    FN_REMOVE     = 2'd1,
    FN_REMOVE_ALL = 2'd2,
    FN_TICK       = 2'd3
  } func_e;

  typedef enum logic [EV_W-1:0] {
    EV_REGISTERED   = 3'd0,
    EV_UNREGISTERED = 3'd1,
    EV_ISSUED       = 3'd2,
    EV_NOT_FOUND    = 3'd3,
    EV_FULL         = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_FLUSH
  } state_e;

  // Flags from the compare unit for the slot currently read
  typedef struct packed {
    logic tag_hit;
    logic free;
    logic fire;
  } match_t;

  // One result transaction without the last flag
  typedef struct packed {
    event_e             ev;
    logic [TAG_W-1:0]   tag;
    logic [INS_W-1:0]   ins;
    logic               dir;
    logic [PRICE_W-1:0] price;
  } res_t;

  // Captured input transaction
  typedef struct packed {
    func_e              func;
    logic [TAG_W-1:0]   tag;
    logic [INS_W-1:0]   ins;
    logic               dir;
    logic [PRICE_W-1:0] trig;
    logic [PRICE_W-1:0] mkt;
  } req_t;

endpackage

`default_nettype wire

>>> src/ptot_in_if.sv
// Input channel of the price trigger order table: valid/ready plus command payload.
// Depends on ptot_pkg for field widths.
`default_nettype none

interface ptot_in_if;
  logic                            valid;
  logic                            ready;
  logic [ptot_pkg::FUNC_W-1:0]     func;
  logic [ptot_pkg::TAG_W-1:0]      order_tag;
  logic [ptot_pkg::INS_W-1:0]      instrument;
  logic                            direction;
  logic [ptot_pkg::PRICE_W-1:0]    trigger_price;
  logic [ptot_pkg::PRICE_W-1:0]    market_price;

  modport source (
    output valid, func, order_tag, instrument, direction, trigger_price, market_price,
    input  ready
  );
  modport sink (
    input  valid, func, order_tag, instrument, direction, trigger_price, market_price,
    output ready
  );
endinterface

`default_nettype wire

>>> src/ptot_out_if.sv
// Output channel of the price trigger order table: valid/ready plus result payload.
// Depends on ptot_pkg for field widths.
`default_nettype none

interface ptot_out_if;
  logic                            valid;
  logic                            ready;
  logic [ptot_pkg::EV_W-1:0]       event_res;
  logic [ptot_pkg::TAG_W-1:0]      out_tag;
  logic [ptot_pkg::INS_W-1:0]      out_instrument;
  logic                            out_direction;
  logic [ptot_pkg::PRICE_W-1:0]    out_price;
  logic                            last;

  modport source (
    output valid, event_res, out_tag, out_instrument, out_direction, out_price, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, out_tag, out_instrument, out_direction, out_price, last,
    output ready
  );
endinterface

`default_nettype wire

>>> src/ptot_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/ptot_match.sv
// Shared compare unit: checks one table slot against the captured command.
// Depends on ptot_pkg for widths and the match flag struct.
`default_nettype none

module ptot_match #(
  parameter int unsigned PW = 32
) (
  input  wire logic                          slot_valid_i,
  input  wire logic [ptot_pkg::TAG_W-1:0]    slot_tag_i,
  input  wire logic [ptot_pkg::INS_W-1:0]    slot_ins_i,
  input  wire logic                          slot_dir_i,
  input  wire logic [PW-1:0]                 slot_price_i,
  input  wire logic [ptot_pkg::TAG_W-1:0]    req_tag_i,
  input  wire logic [ptot_pkg::INS_W-1:0]    req_ins_i,
  input  wire logic [PW-1:0]                 req_mkt_i,
  output ptot_pkg::match_t                   match_o
);

  logic crossed;

  // Direction 0 fires at or above the trigger, direction 1 at or below
  always_comb begin
    if (slot_dir_i) begin
      crossed = (req_mkt_i <= slot_price_i);
    end else begin
      crossed = (req_mkt_i >= slot_price_i);
    end
  end

  assign match_o.tag_hit = slot_valid_i && (slot_tag_i == req_tag_i);
  assign match_o.free    = !slot_valid_i;
  // A zero trigger price never fires
  assign match_o.fire    = slot_valid_i && (slot_ins_i == req_ins_i)
                           && (slot_price_i != '0) && crossed;

endmodule

`default_nettype wire

>>> src/price_trigger_order_table.sv
// Top level of the price trigger order table: sequencer, valid bits and result stage.
// Depends on ptot_pkg, ptot_in_if, ptot_out_if, ptot_ram and ptot_match.
`default_nettype none

// The table holds TABLE_DEPTH pending conditional orders in a one-write, one-read RAM
// with valid bits in flip-flops. Every command (register, remove one, remove all,
// price tick) walks the whole table once in slot order, one slot per cycle through
// the RAM read port and the shared compare unit, unless a result waits on a stalled
// output. After the scan come a finish step and a flush step, and only then does input
// ready return. Results leave through an output register, so the next command is
// taken while the final result of the previous one still waits. Prices are compared
// as unsigned integers on the low PRICE_BITS bits (at most 32). No clearing pass is
// needed after reset.
module price_trigger_order_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PRICE_BITS  = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ptot_in_if.sink         in_i,
  ptot_out_if.source      out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SP = (PRICE_BITS < ptot_pkg::PRICE_W) ? PRICE_BITS
                                                                 : ptot_pkg::PRICE_W;
  localparam int unsigned DW = ptot_pkg::TAG_W + ptot_pkg::INS_W + 1 + SP;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  ptot_pkg::state_e state_q, state_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                   found_q, found_d;
  logic                   free_found_q, free_found_d;
  logic [AW-1:0]          hit_slot_q, hit_slot_d;
  logic [AW-1:0]          free_slot_q, free_slot_d;
  logic                   pend_valid_q, pend_valid_d;
  ptot_pkg::res_t         pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  ptot_pkg::res_t         out_q, out_d;
  logic                   out_last_q, out_last_d;
  ptot_pkg::req_t         req_q, req_d;

  logic                        out_free;
  logic                        push;
  logic                        push_last;
  ptot_pkg::res_t              push_res;
  logic                        ram_we;
  logic [AW-1:0]               ram_wr_addr;
  logic [AW-1:0]               ram_rd_addr;
  logic [DW-1:0]               ram_rd_data;
  logic [ptot_pkg::TAG_W-1:0]  rd_tag;
  logic [ptot_pkg::INS_W-1:0]  rd_ins;
  logic                        rd_dir;
  logic [SP-1:0]               rd_price;
  ptot_pkg::res_t              slot_res;
  ptot_pkg::match_t            match;
  logic [AW-1:0]               target;

  // Slot storage
  ptot_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i ({req_q.tag, req_q.ins, req_q.dir, req_q.trig[SP-1:0]}),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign {rd_tag, rd_ins, rd_dir, rd_price} = ram_rd_data;

  // Compare the slot on the read port against the command
  ptot_match #(
    .PW (SP)
  ) u_match (
    .slot_valid_i (valid_q[ptr_q]),
    .slot_tag_i   (rd_tag),
    .slot_ins_i   (rd_ins),
    .slot_dir_i   (rd_dir),
    .slot_price_i (rd_price),
    .req_tag_i    (req_q.tag),
    .req_ins_i    (req_q.ins),
    .req_mkt_i    (req_q.mkt[SP-1:0]),
    .match_o      (match)
  );

  // Slot contents as a result, event filled in per command
  always_comb begin
    slot_res       = '0;
    slot_res.tag   = rd_tag;
    slot_res.ins   = rd_ins;
    slot_res.dir   = rd_dir;
    slot_res.price = ptot_pkg::PRICE_W'(rd_price);
    case (req_q.func)
      ptot_pkg::FN_TICK: slot_res.ev = ptot_pkg::EV_ISSUED;
      default:           slot_res.ev = ptot_pkg::EV_UNREGISTERED;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign target   = found_q ? hit_slot_q : free_slot_q;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    valid_d      = valid_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    hit_slot_d   = hit_slot_q;
    free_slot_d  = free_slot_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    req_d        = req_q;
    push         = 1'b0;
    push_last    = 1'b0;
    push_res     = pend_q;
    ram_we       = 1'b0;
    ram_wr_addr  = target;
    ram_rd_addr  = '0;
    in_i.ready   = 1'b0;

    // Drop the output transaction once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ptot_pkg::ST_IDLE: begin
        in_i.ready  = 1'b1;
        ram_rd_addr = '0;
        if (in_i.valid) begin
          req_d.func   = ptot_pkg::func_e'(in_i.func);
          req_d.tag    = in_i.order_tag;
          req_d.ins    = in_i.instrument;
          req_d.dir    = in_i.direction;
          req_d.trig   = in_i.trigger_price;
          req_d.mkt    = in_i.market_price;
          ptr_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          pend_valid_d = 1'b0;
          state_d      = ptot_pkg::ST_SCAN;
        end
      end

      ptot_pkg::ST_SCAN: begin
        logic hit;
        logic stall;
        hit   = 1'b0;
        stall = 1'b0;
        case (req_q.func)
          ptot_pkg::FN_REGISTER: begin
            if (match.tag_hit && !found_q) begin
              found_d    = 1'b1;
              hit_slot_d = ptr_q;
            end
            if (match.free && !free_found_q) begin
              free_found_d = 1'b1;
              free_slot_d  = ptr_q;
            end
          end
          ptot_pkg::FN_REMOVE: begin
            // Capture the first matching entry as the pending result
            if (match.tag_hit && !found_q) begin
              found_d      = 1'b1;
              hit_slot_d   = ptr_q;
              pend_d       = slot_res;
              pend_valid_d = 1'b1;
            end
          end
          ptot_pkg::FN_REMOVE_ALL: hit = valid_q[ptr_q];
          ptot_pkg::FN_TICK:       hit = match.fire;
          default:                 hit = 1'b0;
        endcase

        // Hold one result back so the final one can carry the last flag
        if (hit) begin
          if (pend_valid_q && !out_free) begin
            stall = 1'b1;
          end else begin
            push           = pend_valid_q;
            push_res       = pend_q;
            pend_d         = slot_res;
            pend_valid_d   = 1'b1;
            valid_d[ptr_q] = 1'b0;
          end
        end

        if (stall) begin
          ram_rd_addr = ptr_q;
        end else begin
          ram_rd_addr = ptr_q + AW'(1);
          if (ptr_q == LAST_SLOT) begin
            state_d = ptot_pkg::ST_FIN;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end

      ptot_pkg::ST_FIN: begin
        case (req_q.func)
          ptot_pkg::FN_REGISTER: begin
            pend_d.tag   = req_q.tag;
            pend_d.ins   = req_q.ins;
            pend_d.dir   = req_q.dir;
            pend_d.price = ptot_pkg::PRICE_W'(req_q.trig[SP-1:0]);
            pend_valid_d = 1'b1;
            if (found_q || free_found_q) begin
              ram_we          = 1'b1;
              valid_d[target] = 1'b1;
              pend_d.ev       = ptot_pkg::EV_REGISTERED;
            end else begin
              pend_d.ev       = ptot_pkg::EV_FULL;
            end
          end
          ptot_pkg::FN_REMOVE: begin
            if (found_q) begin
              valid_d[hit_slot_q] = 1'b0;
            end else begin
              pend_d       = '0;
              pend_d.ev    = ptot_pkg::EV_NOT_FOUND;
              pend_d.tag   = req_q.tag;
              pend_valid_d = 1'b1;
            end
          end
          default: ;
        endcase
        state_d = ptot_pkg::ST_FLUSH;
      end

      ptot_pkg::ST_FLUSH: begin
        // Release the held result as the final transaction
        if (!pend_valid_q) begin
          state_d = ptot_pkg::ST_IDLE;
        end else if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          push_res     = pend_q;
          pend_valid_d = 1'b0;
          state_d      = ptot_pkg::ST_IDLE;
        end
      end

      default: state_d = ptot_pkg::ST_IDLE;
    endcase

    // Load the output register
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_res;
      out_last_d  = push_last;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptot_pkg::ST_IDLE;
      ptr_q        <= '0;
      valid_q      <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      hit_slot_q   <= '0;
      free_slot_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      valid_q      <= valid_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      hit_slot_q   <= hit_slot_d;
      free_slot_q  <= free_slot_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_res      = out_q.ev;
  assign out_o.out_tag        = out_q.tag;
  assign out_o.out_instrument = out_q.ins;
  assign out_o.out_direction  = out_q.dir;
  assign out_o.out_price      = out_q.price;
  assign out_o.last           = out_last_q;

endmodule

`default_nettype wire

>>> src/ptot_checker.sv
// Port-level assertions for the price trigger order table, bound to the top level.
// Depends on ptot_pkg for event codes.
`default_nettype none

module ptot_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [ptot_pkg::EV_W-1:0]      out_event_i,
  input wire logic [ptot_pkg::TAG_W-1:0]     out_tag_i,
  input wire logic [ptot_pkg::INS_W-1:0]     out_ins_i,
  input wire logic                           out_dir_i,
  input wire logic [ptot_pkg::PRICE_W-1:0]   out_price_i,
  input wire logic                           out_last_i
);

  // A command keeps the block busy in the cycle after its acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_event_i)
      && $stable(out_tag_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Only defined event codes leave the block
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_event_i <= ptot_pkg::EV_FULL)
    else $error("undefined event code");

  // Single-result commands always close with the last flag
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_event_i == ptot_pkg::EV_REGISTERED
      || out_event_i == ptot_pkg::EV_NOT_FOUND || out_event_i == ptot_pkg::EV_FULL)
      |-> out_last_i)
    else $error("single result without last flag");

  // A miss on remove carries no entry contents
  a_not_found_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_event_i == ptot_pkg::EV_NOT_FOUND
      |-> out_ins_i == '0 && !out_dir_i && out_price_i == '0)
    else $error("not-found result carries entry data");

endmodule

bind price_trigger_order_table ptot_checker u_ptot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_event_i (out_o.event_res),
  .out_tag_i   (out_o.out_tag),
  .out_ins_i   (out_o.out_instrument),
  .out_dir_i   (out_o.out_direction),
  .out_price_i (out_o.out_price),
  .out_last_i  (out_o.last)
);

`default_nettype wire
